// File: design/tatd_pkg.sv
// Package for the thermal-aware task dispatcher.
// Holds opcode, status, core class and thermal codes; no dependencies.
package tatd_pkg;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_TAKE   = 2'd1;
    localparam logic [1:0] OP_THERM  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_BACKPRES = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_ISSUED   = 3'd3;
    localparam logic [2:0] ST_MISSED   = 3'd4;
    localparam logic [2:0] ST_NOTASK   = 3'd5;
    localparam logic [2:0] ST_THERMSET = 3'd6;

    localparam logic [2:0] CLS_ANY      = 3'd0;
    localparam logic [2:0] CLS_BIG      = 3'd1;
    localparam logic [2:0] CLS_LITTLE   = 3'd2;
    localparam logic [2:0] CLS_BIG_PREF = 3'd3;
    localparam logic [2:0] CLS_LIT_PREF = 3'd4;

    localparam logic [1:0] TH_NORMAL   = 2'd0;
    localparam logic [1:0] TH_HOT      = 2'd1;
    localparam logic [1:0] TH_CRITICAL = 2'd2;

    typedef struct packed {
        logic [2:0]  cls;
        logic [2:0]  prio;
        logic [15:0] tag;
    } info_t;

endpackage

// File: design/thermal_aware_task_dispatcher.sv
// Top level of the thermal-aware task dispatcher: per-worker task queues in memory,
// a sequencer that walks workers and slots with one shared ordering comparator.
// Depends on tatd_pkg.
// A take reads each slot of each visited queue once through the single memory read
// port. One transaction at a time.
// Reset clears valid bits, counts, sequence counter and thermal state at once.
module thermal_aware_task_dispatcher
    import tatd_pkg::*;
#(
    parameter int NUM_LITTLE  = 4,
    parameter int NUM_BIG     = 2,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: opcode, worker number, task_tag, priority_req, core class,
    // deadline, now_time, thermal_level, zero fill.
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: status, result_tag, chosen_worker, was_stolen, zero fill.
    output logic [23:0]  m_tdata
);

    localparam int NW    = NUM_LITTLE + NUM_BIG;
    localparam int NS    = NW * QUEUE_DEPTH;
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int AW    = (NS > 1) ? $clog2(NS) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int WIDW  = (WW > 3) ? WW : 3;

    typedef enum logic [2:0] {
        S_IDLE, S_PICK, S_FREE, S_SCAN, S_EVAL, S_POP, S_OUT
    } state_t;

    state_t state_reg;
    logic [NS-1:0]          valid_reg;
    logic [CW-1:0]          count_reg [NW];
    logic [63:0]            seq_reg;
    logic [1:0]             therm_reg;
    logic [4:0]             limit_reg;

    info_t                  mem_info   [NS];
    logic [63:0]            mem_dl     [NS];
    logic [63:0]            mem_order  [NS];

    logic [1:0]             op_reg;
    logic [2:0]             wid_reg;
    logic [15:0]            tag_reg;
    logic [2:0]             prio_reg;
    logic [2:0]             cls_reg;
    logic [63:0]            dl_reg;
    logic [63:0]            now_reg;

    logic [WW-1:0]          w_reg;
    logic [SW-1:0]          s_reg;
    logic [WW:0]            visit_reg;
    logic                   found_reg;
    logic [WW-1:0]          bw_reg;
    logic [1:0]             bpen_reg;
    logic [CW-1:0]          bcnt_reg;
    logic                   rd_pend_reg;
    logic [AW-1:0]          rd_addr_reg;
    info_t                  rd_info_reg;
    logic [63:0]            rd_dl_reg;
    logic [63:0]            rd_ord_reg;
    logic [AW-1:0]          b_addr_reg;
    logic [2:0]             b_prio_reg;
    logic [63:0]            b_dl_reg;
    logic [63:0]            b_ord_reg;
    logic [15:0]            b_tag_reg;

    logic [2:0]             o_status_reg;
    logic [15:0]            o_tag_reg;
    logic [2:0]             o_chosen_reg;
    logic                   o_stolen_reg;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;

    function automatic logic may_run(input logic [WW-1:0] w, input logic [2:0] c,
                                     input logic [1:0] th);
        logic big;
        logic crit;
        big  = (32'(w) >= NUM_LITTLE);
        crit = (th == TH_CRITICAL);
        if (crit && big) return 1'b0;
        case (c)
            CLS_BIG:      return big && !crit;
            CLS_LITTLE:   return !big;
            CLS_BIG_PREF: return big || crit;
            CLS_LIT_PREF: return !big || (th != TH_NORMAL);
            default:      return 1'b1;
        endcase
    endfunction

    logic [AW-1:0] slot_addr;
    assign slot_addr = AW'(32'(w_reg) * QUEUE_DEPTH + 32'(s_reg));

    logic [CW-1:0] lim;
    always_comb
    begin
        if (limit_reg == 5'd0)
            lim = CW'(1);
        else if (32'(limit_reg) > QUEUE_DEPTH)
            lim = CW'(QUEUE_DEPTH);
        else
            lim = CW'(limit_reg);
    end

    // Submit candidate evaluation for worker w_reg.
    logic       c_big;
    logic       c_elig;
    logic [1:0] c_pen;
    always_comb
    begin
        c_big  = (32'(w_reg) >= NUM_LITTLE);
        c_elig = 1'b1;
        if (cls_reg == CLS_BIG && !c_big) c_elig = 1'b0;
        if (cls_reg == CLS_LITTLE && c_big) c_elig = 1'b0;
        if (c_big && therm_reg == TH_CRITICAL) c_elig = 1'b0;
        c_pen = 2'd0;
        if (cls_reg == CLS_BIG_PREF) c_pen = c_big ? 2'd0 : 2'd1;
        else if (cls_reg == CLS_LIT_PREF) c_pen = c_big ? 2'd1 : 2'd0;
    end

    // Shared ordering comparator: read entry against current best.
    logic outranks;
    always_comb
    begin
        if (rd_info_reg.prio != b_prio_reg)
            outranks = rd_info_reg.prio > b_prio_reg;
        else if ((rd_dl_reg != 64'd0) != (b_dl_reg != 64'd0))
            outranks = rd_dl_reg != 64'd0;
        else if (rd_dl_reg != 64'd0 && rd_dl_reg != b_dl_reg)
            outranks = rd_dl_reg < b_dl_reg;
        else
            outranks = rd_ord_reg > b_ord_reg;
    end

    // The taking worker decides which classes may run.
    logic rd_ok;
    assign rd_ok = rd_pend_reg && may_run(WW'(wid_reg), rd_info_reg.cls, therm_reg);

    logic [WW-1:0] w_wrap;
    assign w_wrap = (32'(w_reg) == NW - 1) ? WW'(0) : WW'(32'(w_reg) + 1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_info[wr_addr]  <= '{cls: cls_reg, prio: prio_reg, tag: tag_reg};
            mem_dl[wr_addr]    <= dl_reg;
            mem_order[wr_addr] <= seq_reg - 64'd1;
        end
        rd_info_reg <= mem_info[slot_addr];
        rd_dl_reg   <= mem_dl[slot_addr];
        rd_ord_reg  <= mem_order[slot_addr];
    end

    assign wr_en   = (state_reg == S_FREE) && !valid_reg[slot_addr];
    assign wr_addr = slot_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            for (int i = 0; i < NW; i++) count_reg[i] <= '0;
            seq_reg      <= '0;
            therm_reg    <= TH_NORMAL;
            limit_reg    <= 5'd16;
            found_reg    <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we) limit_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg   <= s_tdata[1:0];
                        wid_reg  <= s_tdata[4:2];
                        tag_reg  <= s_tdata[20:5];
                        prio_reg <= s_tdata[23:21];
                        cls_reg  <= (s_tdata[26:24] > CLS_LIT_PREF) ? CLS_ANY : s_tdata[26:24];
                        dl_reg   <= s_tdata[90:27];
                        now_reg  <= s_tdata[154:91];
                        o_status_reg <= ST_REJECTED;
                        o_tag_reg    <= 16'd0;
                        o_chosen_reg <= 3'd0;
                        o_stolen_reg <= 1'b0;
                        w_reg        <= '0;
                        s_reg        <= '0;
                        found_reg    <= 1'b0;
                        visit_reg    <= '0;
                        rd_pend_reg  <= 1'b0;
                        case (s_tdata[1:0])
                            OP_THERM:
                            begin
                                therm_reg    <= (s_tdata[156:155] > TH_CRITICAL) ?
                                                TH_CRITICAL : s_tdata[156:155];
                                o_status_reg <= ST_THERMSET;
                                state_reg    <= S_OUT;
                            end
                            OP_SUBMIT:
                                state_reg <= S_PICK;
                            OP_TAKE:
                            begin
                                o_chosen_reg <= s_tdata[4:2];
                                o_status_reg <= ST_NOTASK;
                                if (32'(s_tdata[4:2]) < NW)
                                begin
                                    w_reg     <= WW'(s_tdata[4:2]);
                                    state_reg <= S_SCAN;
                                end
                                else
                                    state_reg <= S_OUT;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_PICK:
                begin
                    if (32'(w_reg) == 0)
                    begin
                        if ((dl_reg != 64'd0 && dl_reg <= now_reg) ||
                            (therm_reg == TH_CRITICAL && cls_reg == CLS_BIG))
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                            seq_reg <= seq_reg + 64'd1;
                    end
                    if (!((32'(w_reg) == 0) && ((dl_reg != 64'd0 && dl_reg <= now_reg) ||
                          (therm_reg == TH_CRITICAL && cls_reg == CLS_BIG))))
                    begin
                        if (c_elig && (!found_reg || c_pen < bpen_reg ||
                            (c_pen == bpen_reg && count_reg[w_reg] < bcnt_reg)))
                        begin
                            found_reg <= 1'b1;
                            bw_reg    <= w_reg;
                            bpen_reg  <= c_pen;
                            bcnt_reg  <= count_reg[w_reg];
                        end
                        if (32'(w_reg) == NW - 1)
                            state_reg <= S_EVAL;
                        else
                            w_reg <= WW'(32'(w_reg) + 1);
                    end
                end
                S_EVAL:
                begin
                    if (!found_reg)
                        state_reg <= S_OUT;
                    else
                    begin
                        o_chosen_reg <= 3'(bw_reg);
                        if (count_reg[bw_reg] >= lim)
                        begin
                            o_status_reg <= ST_BACKPRES;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            o_status_reg <= ST_ACCEPTED;
                            w_reg        <= bw_reg;
                            s_reg        <= '0;
                            state_reg    <= S_FREE;
                        end
                    end
                end
                S_FREE:
                begin
                    if (!valid_reg[slot_addr])
                    begin
                        valid_reg[slot_addr] <= 1'b1;
                        count_reg[w_reg]     <= count_reg[w_reg] + CW'(1);
                        state_reg            <= S_OUT;
                    end
                    else if (32'(s_reg) == QUEUE_DEPTH - 1)
                        state_reg <= S_OUT;
                    else
                        s_reg <= SW'(32'(s_reg) + 1);
                end
                S_SCAN:
                begin
                    // Issue a read of slot_addr; evaluate last cycle's read.
                    rd_pend_reg <= valid_reg[slot_addr];
                    rd_addr_reg <= slot_addr;
                    if (rd_ok && (!found_reg || outranks))
                    begin
                        found_reg  <= 1'b1;
                        b_addr_reg <= rd_addr_reg;
                        b_prio_reg <= rd_info_reg.prio;
                        b_dl_reg   <= rd_dl_reg;
                        b_ord_reg  <= rd_ord_reg;
                        b_tag_reg  <= rd_info_reg.tag;
                    end
                    if (32'(s_reg) == QUEUE_DEPTH - 1)
                        state_reg <= S_POP;
                    else
                        s_reg <= SW'(32'(s_reg) + 1);
                end
                S_POP:
                begin
                    logic     got;
                    logic [AW-1:0] a;
                    got = found_reg;
                    a   = b_addr_reg;
                    if (rd_ok && (!found_reg || outranks))
                    begin
                        got = 1'b1;
                        a   = rd_addr_reg;
                        b_tag_reg <= rd_info_reg.tag;
                        b_dl_reg  <= rd_dl_reg;
                    end
                    rd_pend_reg <= 1'b0;
                    s_reg       <= '0;
                    if (got)
                    begin
                        valid_reg[a] <= 1'b0;
                        if (count_reg[w_reg] != '0) count_reg[w_reg] <= count_reg[w_reg] - CW'(1);
                        o_stolen_reg <= (visit_reg != '0);
                        b_addr_reg   <= a;
                        found_reg    <= 1'b1;
                        o_status_reg <= ST_ISSUED;
                        state_reg    <= S_OUT;
                        visit_reg    <= '1;
                    end
                    else if (32'(visit_reg) >= NW - 1)
                        state_reg <= S_OUT;
                    else
                    begin
                        visit_reg <= visit_reg + (WW+1)'(1);
                        w_reg     <= w_wrap;
                        state_reg <= S_SCAN;
                    end
                end
                S_OUT:
                begin
                    if (op_reg == OP_TAKE && o_status_reg == ST_ISSUED && found_reg)
                    begin
                        found_reg <= 1'b0;
                        o_tag_reg <= b_tag_reg;
                        if (b_dl_reg != 64'd0 && now_reg > b_dl_reg)
                            o_status_reg <= ST_MISSED;
                    end
                    else if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) &&
                      !(op_reg == OP_TAKE && o_status_reg == ST_ISSUED && found_reg);
    assign m_tdata  = {1'b0, o_stolen_reg, o_chosen_reg, o_tag_reg, o_status_reg};

    logic unused_ok;
    assign unused_ok = ^{s_tdata[159:157], wid_reg, 5'(WIDW)};

endmodule

// File: verif/tb.sv
// Testbench for the thermal-aware task dispatcher: drives directed and random submits, takes
// and thermal changes through the stream ports and checks each result against a scoreboard predictor.
// Depends on tatd_pkg and thermal_aware_task_dispatcher.
`timescale 1ns / 1ps

import tatd_pkg::*;

class dispatch_scoreboard;
    localparam int NW = 6;
    localparam int QD = 16;
    localparam int FD = 256;
    bit          slot_used[NW*QD];
    info_t       slot_info[NW*QD];
    logic [63:0] slot_dl[NW*QD];
    logic [63:0] slot_seq[NW*QD];
    int          depth[NW];
    logic [63:0] seq_ctr;
    logic [1:0]  therm;
    logic [4:0]  limit;
    logic [23:0] exp_fifo[FD];
    int          rd_ptr;
    int          wr_ptr;
    int          errors;
    int          checked;

    function new();
        foreach (slot_used[i]) slot_used[i] = 0;
        foreach (depth[i]) depth[i] = 0;
        seq_ctr = 0;
        therm = TH_NORMAL;
        limit = 16;
        rd_ptr = 0;
        wr_ptr = 0;
        errors = 0;
        checked = 0;
    endfunction

    function int outstanding();
        return wr_ptr - rd_ptr;
    endfunction

    function bit allowed(int w, logic [2:0] c);
        bit big;
        bit crit;
        big = w >= 4;
        crit = therm == TH_CRITICAL;
        if (crit && big) return 0;
        case (c)
            CLS_BIG:      return big && !crit;
            CLS_LITTLE:   return !big;
            CLS_BIG_PREF: return big || crit;
            CLS_LIT_PREF: return !big || therm >= TH_HOT;
            default:      return 1;
        endcase
    endfunction

    function bit beats(int a, int b);
        logic [63:0] da;
        logic [63:0] db;
        da = slot_dl[a];
        db = slot_dl[b];
        if (slot_info[a].prio != slot_info[b].prio)
            return slot_info[a].prio > slot_info[b].prio;
        if ((da != 0) != (db != 0)) return da != 0;
        if (da != 0 && da != db) return da < db;
        return slot_seq[a] > slot_seq[b];
    endfunction

    function int pick_in(int q, int w);
        int best;
        int k;
        best = -1;
        for (int s = 0; s < QD; s++) begin
            k = q * QD + s;
            if (slot_used[k] && allowed(w, slot_info[k].cls))
                if (best < 0 || beats(k, best)) best = k;
        end
        return best;
    endfunction

    function void note_input(logic [159:0] d);
        logic [1:0]  op;
        logic [2:0]  wid;
        logic [15:0] tag;
        logic [2:0]  prio;
        logic [2:0]  cls;
        logic [63:0] dl;
        logic [63:0] now;
        logic [1:0]  lvl;
        logic [2:0]  st;
        logic [15:0] rtag;
        logic [2:0]  chosen;
        bit          stolen;
        int best;
        int bpen;
        int bcnt;
        int pen;
        int lim;
        int k;
        int start;
        op = d[1:0];
        wid = d[4:2];
        tag = d[20:5];
        prio = d[23:21];
        cls = d[26:24];
        dl = d[90:27];
        now = d[154:91];
        lvl = d[156:155];
        rtag = 0;
        chosen = 0;
        stolen = 0;
        st = ST_REJECTED;
        if (op == OP_NONE) return;
        if (op == OP_THERM) begin
            therm = lvl > TH_CRITICAL ? TH_CRITICAL : lvl;
            st = ST_THERMSET;
        end else if (op == OP_SUBMIT) begin
            if (cls > CLS_LIT_PREF) cls = CLS_ANY;
            if (!((dl != 0 && dl <= now) || (therm == TH_CRITICAL && cls == CLS_BIG))) begin
                best = -1;
                bpen = 0;
                bcnt = 0;
                for (int w = 0; w < NW; w++) begin
                    pen = 0;
                    if (cls == CLS_BIG && w < 4) continue;
                    if (cls == CLS_LITTLE && w >= 4) continue;
                    if (w >= 4 && therm == TH_CRITICAL) continue;
                    if (cls == CLS_BIG_PREF) pen = w >= 4 ? 0 : 1;
                    else if (cls == CLS_LIT_PREF) pen = w >= 4 ? 1 : 0;
                    if (best < 0 || pen < bpen || (pen == bpen && depth[w] < bcnt)) begin
                        best = w;
                        bpen = pen;
                        bcnt = depth[w];
                    end
                end
                if (best >= 0) begin
                    lim = limit == 0 ? 1 : (limit > QD ? QD : limit);
                    chosen = 3'(best);
                    if (depth[best] >= lim) st = ST_BACKPRES;
                    else begin
                        for (int s = 0; s < QD; s++) begin
                            k = best * QD + s;
                            if (!slot_used[k]) begin
                                slot_used[k] = 1;
                                slot_info[k] = '{cls: cls, prio: prio, tag: tag};
                                slot_dl[k] = dl;
                                slot_seq[k] = seq_ctr;
                                depth[best]++;
                                break;
                            end
                        end
                        st = ST_ACCEPTED;
                    end
                end
                seq_ctr = seq_ctr + 64'd1;
            end
        end else begin
            k = -1;
            chosen = wid;
            if (wid < NW) begin
                k = pick_in(wid, wid);
                start = (wid + 1) % NW;
                for (int off = 0; off < NW - 1 && k < 0; off++) begin
                    k = pick_in((start + off) % NW, wid);
                    if (k >= 0) stolen = 1;
                end
            end
            if (k < 0) st = ST_NOTASK;
            else begin
                slot_used[k] = 0;
                if (depth[k / QD] > 0) depth[k / QD]--;
                rtag = slot_info[k].tag;
                st = (slot_dl[k] != 0 && now > slot_dl[k]) ? ST_MISSED : ST_ISSUED;
            end
        end
        exp_fifo[wr_ptr % FD] = {1'b0, stolen, chosen, rtag, st};
        wr_ptr++;
    endfunction

    function void check_result(logic [23:0] r);
        logic [23:0] e;
        if (outstanding() == 0) begin
            $error("unexpected result %h", r);
            errors++;
            return;
        end
        e = exp_fifo[rd_ptr % FD];
        rd_ptr++;
        checked++;
        if (r[2:0] != e[2:0]) begin
            $error("status expected %0d actual %0d", e[2:0], r[2:0]);
            errors++;
        end
        if (r[18:3] != e[18:3]) begin
            $error("result_tag expected %0d actual %0d", e[18:3], r[18:3]);
            errors++;
        end
        if (r[21:19] != e[21:19]) begin
            $error("chosen_worker expected %0d actual %0d", e[21:19], r[21:19]);
            errors++;
        end
        if (r[22] != e[22]) begin
            $error("was_stolen expected %0d actual %0d", e[22], r[22]);
            errors++;
        end
        if (r[23] != 1'b0) begin
            $error("fill expected 0 actual %0d", r[23]);
            errors++;
        end
    endfunction
endclass

module tb;
    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [4:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    dispatch_scoreboard board;
    longint       cycles;
    logic [63:0]  clock_ns;
    bit           recv_quiet;

    thermal_aware_task_dispatcher dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    function int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("thermal_aware_task_dispatcher test failed");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    initial
    begin
        int n;
        m_tready = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (recv_quiet || $urandom_range(0, 2) != 0) m_tready = 1;
            else begin
                m_tready = 0;
                n = gap_len();
                repeat (n) @(negedge clk);
                m_tready = 1;
            end
        end
    end

    task automatic send(logic [1:0] op, logic [2:0] wid, logic [15:0] tag, logic [2:0] prio,
                        logic [2:0] cls, logic [63:0] dl, logic [63:0] now, logic [1:0] lvl);
        s_tdata = {3'b0, lvl, now, dl, cls, prio, tag, wid, op};
        s_tvalid = 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_input(s_tdata);
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        while (board.outstanding() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        drain();
        cfg_data = v;
        cfg_we = 1;
        @(negedge clk);
        cfg_we = 0;
        board.limit = v;
    endtask

    function logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_item();
        int pick;
        logic [63:0] dl;
        logic [63:0] now;
        pick = $urandom_range(0, 99);
        now = clock_ns;
        case ($urandom_range(0, 9))
            0: dl = 0;
            1: dl = rnd64();
            2: dl = now - 64'($urandom_range(0, 50));
            default: dl = now + 64'($urandom_range(1, 2000));
        endcase
        if ($urandom_range(0, 49) == 0) now = rnd64();
        clock_ns = clock_ns + 64'($urandom_range(0, 40));
        if (pick < 50)
            send(OP_SUBMIT, 3'($urandom()), 16'($urandom()), 3'($urandom()),
                 $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                 dl, now, 2'($urandom()));
        else if (pick < 92)
            send(OP_TAKE, $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5)),
                 16'($urandom()), 3'($urandom()), 3'($urandom()), rnd64(), now,
                 2'($urandom()));
        else if (pick < 98)
            send(OP_THERM, 3'($urandom()), 16'($urandom()), 3'($urandom()), 3'($urandom()),
                 rnd64(), now, 2'($urandom()));
        else
            send(OP_NONE, 3'($urandom()), 16'($urandom()), 3'($urandom()), 3'($urandom()),
                 rnd64(), rnd64(), 2'($urandom()));
        idle_gap();
    endtask

    initial
    begin
        logic [4:0] limits[6];
        board = new();
        cycles = 0;
        clock_ns = 1000;
        recv_quiet = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(OP_TAKE, 0, 0, 0, CLS_ANY, 0, 0, 0);
        send(OP_SUBMIT, 0, 16'hFFFF, 7, CLS_ANY, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(OP_SUBMIT, 0, 16'h0000, 0, CLS_BIG, 64'hFFFF_FFFF_FFFF_FFFF, 5, 3);
        send(OP_SUBMIT, 0, 16'h1234, 3, CLS_LITTLE, 100, 100, 0);
        send(OP_SUBMIT, 0, 16'h2345, 3, CLS_BIG_PREF, 200, 100, 0);
        send(OP_SUBMIT, 0, 16'h3456, 3, CLS_LIT_PREF, 150, 100, 0);
        send(OP_SUBMIT, 0, 16'h4567, 5, 3'd7, 0, 0, 0);
        send(OP_TAKE, 4, 0, 0, 0, 0, 300, 0);
        send(OP_TAKE, 5, 0, 0, 0, 0, 0, 0);
        send(OP_TAKE, 6, 0, 0, 0, 0, 0, 0);
        send(OP_TAKE, 7, 0, 0, 0, 0, 0, 0);
        send(OP_THERM, 0, 0, 0, 0, 0, 0, TH_HOT);
        send(OP_SUBMIT, 0, 16'h5678, 1, CLS_LIT_PREF, 0, 0, 0);
        send(OP_THERM, 0, 0, 0, 0, 0, 0, 2'd3);
        send(OP_SUBMIT, 0, 16'h6789, 2, CLS_BIG, 0, 0, 0);
        send(OP_SUBMIT, 0, 16'h789A, 2, CLS_BIG_PREF, 0, 0, 0);
        send(OP_TAKE, 4, 0, 0, 0, 0, 0, 0);
        send(OP_NONE, 7, 16'hFFFF, 7, 7, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3);
        send(OP_THERM, 0, 0, 0, 0, 0, 0, TH_NORMAL);
        for (int i = 0; i < 6; i++) send(OP_TAKE, 3'(i), 0, 0, 0, 0, 0, 0);

        limits = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd8};
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            for (int i = 0; i < 340; i++) begin
                random_item();
                if (ph == 2 && i == 170) begin
                    recv_quiet = 1;
                    drain();
                    recv_quiet = 0;
                end
            end
        end

        while (board.outstanding() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Checked %0d results over six queue limit settings, including 0, 1 and 31.",
                 board.checked);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("thermal_aware_task_dispatcher test passed");
        else
            $display("thermal_aware_task_dispatcher test failed");
        $finish;
    end
endmodule
